// ----- sv/uutd_pkg.sv -----
// ----------------------------------------------------------------------------
// uutd_pkg
// Shared types and constants of the uu text decoder.
// ----------------------------------------------------------------------------
package uutd_pkg;

  // Line length above which the sticky error is raised (newline not counted)
  localparam int unsigned LINE_LIMIT  = 126;
  // Width of the saturating byte total
  localparam int unsigned TOTAL_WIDTH = 24;
  // Entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Character codes
  localparam logic [7:0] CHAR_NL         = 8'd10;
  localparam logic [7:0] CHAR_BASE       = 8'd32;
  localparam logic [7:0] CHAR_COUNT_MAX  = 8'd77;
  localparam logic [7:0] CHAR_VALID_MAX  = 8'd96;

  // Result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Input request
  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } in_req_t;

  // Output result
  typedef struct packed {
    logic                   kind;
    logic [7:0]             data_byte;
    logic                   error;
    logic [TOTAL_WIDTH-1:0] total_bytes;
    logic                   last;
  } out_rsp_t;

  // Work handed from front to back: up to three bytes and an optional status
  typedef struct packed {
    logic [23:0]            word;
    logic [1:0]             num_bytes;
    logic                   status;
    logic                   error;
    logic [TOTAL_WIDTH-1:0] total;
  } bundle_t;

  // Queue handshake driven by the front
  typedef struct packed {
    logic push;
  } q_ctrl_t;

endpackage

// ----- sv/uu_text_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// uu_text_decoder_unit
// Streaming uudecoder: one text character in, decoded bytes and a final
// status item out.
// ----------------------------------------------------------------------------
// The unit takes one character per clock cycle whenever its four-entry
// bundle queue has room. Each character is decoded in the cycle it is
// accepted; a completed group of four characters places up to three bytes
// in the queue, and the final character of the text adds a status item
// after them. The result port gives one result per cycle while the
// receiver is ready; a bundle is registered in the queue on acceptance
// and its results leave in order once it is at the head. With three bytes
// per four characters the output keeps pace with a full-rate character
// stream; the input stalls only while the queue is full.
module uu_text_decoder_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  uutd_pkg::in_req_t   in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output uutd_pkg::out_rsp_t  out_rsp_o
);

  uutd_pkg::q_ctrl_t q_ctrl;
  uutd_pkg::bundle_t push_bundle;
  uutd_pkg::bundle_t head_bundle;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;

  uutd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .q_full_i   (q_full),
    .q_ctrl_o   (q_ctrl),
    .bundle_o   (push_bundle)
  );

  uutd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_ctrl_i (q_ctrl),
    .bundle_i (push_bundle),
    .full_o   (q_full),
    .valid_o  (q_valid),
    .pop_i    (q_pop),
    .bundle_o (head_bundle)
  );

  uutd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .bundle_i    (head_bundle),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// ----- sv/uutd_front.sv -----
// ----------------------------------------------------------------------------
// uutd_front
// Accepts one character per cycle while the queue has room, tracks line and group
// state and turns each character into a bundle of decoded bytes and/or a final status.
// ----------------------------------------------------------------------------
module uutd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  uutd_pkg::in_req_t  in_req_i,
  input  logic               q_full_i,
  output uutd_pkg::q_ctrl_t  q_ctrl_o,
  output uutd_pkg::bundle_t  bundle_o
);

  logic [6:0]                       line_chars_q, line_chars_d;
  logic [5:0]                       line_count_q, line_count_d;
  logic                             line_is_data_q, line_is_data_d;
  logic [17:0]                      group_values_q, group_values_d;
  logic [1:0]                       group_pos_q, group_pos_d;
  logic                             group_broken_q, group_broken_d;
  logic [5:0]                       line_bytes_out_q, line_bytes_out_d;
  logic [uutd_pkg::TOTAL_WIDTH-1:0] total_out_q, total_out_d;
  logic                             failed_q, failed_d;

  logic                             accept;
  logic                             is_nl;
  logic                             end_now;
  logic                             first;
  logic [6:0]                       chars_inc;
  logic                             failed_eff;
  logic                             ins;
  logic                             broken_eff;
  logic [7:0]                       c_off;
  logic [5:0]                       v;
  logic [23:0]                      ins_word;
  logic [23:0]                      word;
  logic [2:0]                       pos_eff;
  logic                             do_finish;
  logic [5:0]                       remain;
  logic [1:0]                       num_bytes;
  logic [uutd_pkg::TOTAL_WIDTH:0]   total_sum;
  logic [uutd_pkg::TOTAL_WIDTH-1:0] total_new;

  assign accept     = in_valid_i & ~q_full_i;
  assign in_ready_o = ~q_full_i;

  // Classify the character
  assign is_nl     = (in_req_i.ch == uutd_pkg::CHAR_NL);
  assign end_now   = is_nl | in_req_i.end_of_text;
  assign first     = (line_chars_q == 7'd0);
  assign chars_inc = (line_chars_q == 7'h7f) ? line_chars_q : line_chars_q + 7'd1;
  assign failed_eff = failed_q |
                      (~is_nl & (chars_inc > 7'(uutd_pkg::LINE_LIMIT)));

  // Body character value, zero once the group is broken
  assign ins        = ~is_nl & ~first & line_is_data_q;
  assign broken_eff = group_broken_q | (in_req_i.ch < uutd_pkg::CHAR_BASE) |
                      (in_req_i.ch > uutd_pkg::CHAR_VALID_MAX);
  assign c_off      = in_req_i.ch - uutd_pkg::CHAR_BASE;
  assign v          = broken_eff ? 6'd0 : c_off[5:0];

  // Place the value at its slot, least significant first
  always_comb begin
    ins_word = 24'd0;
    case (group_pos_q)
      2'd0:    ins_word = {18'd0, v};
      2'd1:    ins_word = {12'd0, v, 6'd0};
      2'd2:    ins_word = {6'd0, v, 12'd0};
      2'd3:    ins_word = {v, 18'd0};
      default: ins_word = 24'd0;
    endcase
  end

  assign word    = {6'd0, group_values_q} | (ins ? ins_word : 24'd0);
  assign pos_eff = {1'b0, group_pos_q} + {2'd0, ins};

  // A group completes on its fourth value or is padded at line end
  assign do_finish = line_is_data_q &
                     ((pos_eff == 3'd4) | (end_now & (pos_eff != 3'd0)));
  assign remain    = line_count_q - line_bytes_out_q;

  always_comb begin
    num_bytes = 2'd0;
    if (do_finish && !failed_eff && (line_bytes_out_q < line_count_q)) begin
      num_bytes = (remain >= 6'd3) ? 2'd3 : remain[1:0];
    end
  end

  // Saturating total
  assign total_sum = {1'b0, total_out_q} + {{(uutd_pkg::TOTAL_WIDTH - 1){1'b0}}, num_bytes};
  assign total_new = total_sum[uutd_pkg::TOTAL_WIDTH] ? {uutd_pkg::TOTAL_WIDTH{1'b1}}
                                                      : total_sum[uutd_pkg::TOTAL_WIDTH-1:0];

  // Next state
  always_comb begin
    line_chars_d     = line_chars_q;
    line_count_d     = line_count_q;
    line_is_data_d   = line_is_data_q;
    group_values_d   = group_values_q;
    group_pos_d      = group_pos_q;
    group_broken_d   = group_broken_q;
    line_bytes_out_d = line_bytes_out_q + {4'd0, num_bytes};
    total_out_d      = total_new;
    failed_d         = failed_eff;
    if (!is_nl) begin
      line_chars_d = chars_inc;
      if (first && (in_req_i.ch > uutd_pkg::CHAR_BASE) &&
          (in_req_i.ch <= uutd_pkg::CHAR_COUNT_MAX)) begin
        line_is_data_d = 1'b1;
        line_count_d   = c_off[5:0];
      end
      if (ins) begin
        if (pos_eff == 3'd4) begin
          group_values_d = 18'd0;
          group_pos_d    = 2'd0;
          group_broken_d = 1'b0;
        end else begin
          group_values_d = word[17:0];
          group_pos_d    = pos_eff[1:0];
          group_broken_d = broken_eff;
        end
      end
    end
    if (end_now) begin
      line_chars_d     = 7'd0;
      line_count_d     = 6'd0;
      line_is_data_d   = 1'b0;
      group_values_d   = 18'd0;
      group_pos_d      = 2'd0;
      group_broken_d   = 1'b0;
      line_bytes_out_d = 6'd0;
    end
    if (in_req_i.end_of_text) begin
      total_out_d = '0;
      failed_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_chars_q     <= 7'd0;
      line_count_q     <= 6'd0;
      line_is_data_q   <= 1'b0;
      group_values_q   <= 18'd0;
      group_pos_q      <= 2'd0;
      group_broken_q   <= 1'b0;
      line_bytes_out_q <= 6'd0;
      total_out_q      <= '0;
      failed_q         <= 1'b0;
    end else if (accept) begin
      line_chars_q     <= line_chars_d;
      line_count_q     <= line_count_d;
      line_is_data_q   <= line_is_data_d;
      group_values_q   <= group_values_d;
      group_pos_q      <= group_pos_d;
      group_broken_q   <= group_broken_d;
      line_bytes_out_q <= line_bytes_out_d;
      total_out_q      <= total_out_d;
      failed_q         <= failed_d;
    end
  end

  // Bundle toward the queue
  assign q_ctrl_o.push = accept & ((num_bytes != 2'd0) | in_req_i.end_of_text);

  assign bundle_o.word      = word;
  assign bundle_o.num_bytes = num_bytes;
  assign bundle_o.status    = in_req_i.end_of_text;
  assign bundle_o.error     = failed_eff;
  assign bundle_o.total     = total_new;

  // Checks
  a_bytes_in_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_bytes_out_q <= line_count_q)
    else $error("bytes emitted exceed line count");

  a_no_data_after_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |-> (num_bytes == 2'd0))
    else $error("data emitted after length error");

  a_group_idle_off_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !line_is_data_q |-> (group_pos_q == 2'd0))
    else $error("open group on a skipped line");

endmodule

// ----- sv/uutd_queue.sv -----
// ----------------------------------------------------------------------------
// uutd_queue
// Short register queue of bundles between the front and the back.
// ----------------------------------------------------------------------------
module uutd_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  uutd_pkg::q_ctrl_t     q_ctrl_i,
  input  uutd_pkg::bundle_t     bundle_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  logic                  pop_i,
  output uutd_pkg::bundle_t     bundle_o
);

  uutd_pkg::bundle_t                 entry_q [uutd_pkg::QUEUE_DEPTH];
  logic [uutd_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [uutd_pkg::QPTR_W:0]         count_q, count_d;
  logic                              do_push, do_pop;

  assign full_o   = (count_q == (uutd_pkg::QPTR_W + 1)'(uutd_pkg::QUEUE_DEPTH));
  assign valid_o  = (count_q != '0);
  assign do_push  = q_ctrl_i.push;
  assign do_pop   = pop_i & valid_o;
  assign bundle_o = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + (uutd_pkg::QPTR_W + 1)'(1);
      2'b01:   count_d = count_q - (uutd_pkg::QPTR_W + 1)'(1);
      default: count_d = count_q;
    endcase
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + (uutd_pkg::QPTR_W)'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + (uutd_pkg::QPTR_W)'(1);
      count_q <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= bundle_i;
    end
  end

  // Checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !do_push)
    else $error("push into full queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (uutd_pkg::QPTR_W + 1)'(uutd_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

  a_entry_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (bundle_o.status || (bundle_o.num_bytes != 2'd0)))
    else $error("empty bundle queued");

endmodule

// ----- sv/uutd_back.sv -----
// ----------------------------------------------------------------------------
// uutd_back
// Expands the head bundle into one result per cycle while out_ready_i is
// high: data bytes low byte first, then the status item if present.
// ----------------------------------------------------------------------------
module uutd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  uutd_pkg::bundle_t    bundle_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output uutd_pkg::out_rsp_t   out_rsp_o
);

  logic [1:0] idx_q, idx_d;
  logic [2:0] num_res;
  logic       is_last;
  logic       fire;
  logic       is_data;

  assign num_res = {1'b0, bundle_i.num_bytes} + {2'd0, bundle_i.status};
  assign is_last = ({1'b0, idx_q} == (num_res - 3'd1));
  assign is_data = (idx_q < bundle_i.num_bytes);
  assign fire    = q_valid_i & out_ready_i;
  assign pop_o   = fire & is_last;

  assign out_valid_o = q_valid_i;

  // Result fields
  always_comb begin
    out_rsp_o.kind        = uutd_pkg::KIND_STATUS;
    out_rsp_o.data_byte   = 8'd0;
    out_rsp_o.error       = bundle_i.error;
    out_rsp_o.total_bytes = bundle_i.total;
    out_rsp_o.last        = is_last;
    if (is_data) begin
      out_rsp_o.kind        = uutd_pkg::KIND_DATA;
      out_rsp_o.error       = 1'b0;
      out_rsp_o.total_bytes = '0;
      case (idx_q)
        2'd0:    out_rsp_o.data_byte = bundle_i.word[7:0];
        2'd1:    out_rsp_o.data_byte = bundle_i.word[15:8];
        2'd2:    out_rsp_o.data_byte = bundle_i.word[23:16];
        default: out_rsp_o.data_byte = 8'd0;
      endcase
    end
  end

  // Position within the head bundle
  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

  // Checks
  a_idx_in_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_i |-> ({1'b0, idx_q} < num_res))
    else $error("result index beyond bundle");

  a_idx_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (idx_q == 2'd0))
    else $error("index not rewound after bundle");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.kind == uutd_pkg::KIND_STATUS) |-> out_rsp_o.last)
    else $error("status item not last");

endmodule
